[rtl/core/sdq_pkg.sv]
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and constants of the segment display queue.
// ----------------------------------------------------------------------------
package sdq_pkg;

  // Default geometry
  localparam int unsigned SdqSlots    = 20;
  localparam int unsigned SdqDigits   = 4;
  localparam int unsigned SdqChannels = 2;

  // Configuration port
  localparam int unsigned SdqCfgIdxW  = 1;
  localparam int unsigned SdqCfgDataW = 8;
  localparam logic [SdqCfgIdxW-1:0] REG_DISPLAY_ENABLED = 1'b0;
  localparam logic [SdqCfgIdxW-1:0] REG_IDLE_PATTERN    = 1'b1;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_LOCK    = 2'd1,
    OP_REFRESH = 2'd2
  } sdq_op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_DISABLED = 2'd2
  } sdq_status_e;

  // One request
  typedef struct packed {
    logic [1:0]  operation;
    logic        channel;
    logic [31:0] segments;
    logic [6:0]  show_count;
    logic [4:0]  lock_slot;
    logic        lock_enable;
  } sdq_req_t;

  // One result
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot_written;
    logic [7:0] seg_first;
    logic [7:0] seg_second;
    logic [3:0] digit_select;
    logic       last;
  } sdq_res_t;

  // One slot memory entry
  typedef struct packed {
    logic [6:0]  count;
    logic [31:0] segs;
  } sdq_slot_t;

endpackage

[rtl/core/sdq_ram.sv]
// ----------------------------------------------------------------------------
// sdq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/segment_display_queue_unit.sv]
// ----------------------------------------------------------------------------
// segment_display_queue_unit
// Two-channel slot queue for multi-digit segment displays.
// ----------------------------------------------------------------------------
// A write or lock request answers with one result in the cycle after it is
// taken, and busy stays low, so such requests may follow every cycle. A
// refresh while enabled reads the shown slot of each channel from its slot
// memory at the edge that takes it, then builds one frame per cycle, with
// the repeat count of each unlocked channel written back on the final frame;
// busy is high while the frames are built, and each frame result shows in
// the cycle after it is built. A refresh while disabled, or an unknown
// operation, answers in the cycle after it is taken, as a write does.
// Results are strobed for exactly one cycle and cannot be held off. The slot
// store reads as cleared right after reset (per-entry valid flags), so no
// clearing pass is needed.
module segment_display_queue_unit #(
  parameter int unsigned SLOTS  = sdq_pkg::SdqSlots,
  parameter int unsigned DIGITS = sdq_pkg::SdqDigits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  sdq_pkg::sdq_req_t               req_i,
  output logic                            result_valid_o,
  output sdq_pkg::sdq_res_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [sdq_pkg::SdqCfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdq_pkg::SdqCfgDataW-1:0] cfg_data_i
);

  import sdq_pkg::*;

  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned DW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned CH    = SdqChannels;
  localparam int unsigned SLOTW = $bits(sdq_slot_t);

  typedef enum logic {
    S_IDLE,
    S_FRAME
  } state_e;

  state_e          state_q;
  logic [DW-1:0]   dig_q;
  logic            enabled_q;
  logic [7:0]      idle_q;
  logic [SW-1:0]   show_q   [CH];
  logic [SW-1:0]   wptr_q   [CH];
  logic [SW-1:0]   pinned_q [CH];
  logic [CH-1:0]   pin_q;
  logic [SLOTS-1:0] valid_q [CH];
  logic            res_valid_q;
  sdq_res_t        res_q;

  logic            accept;
  logic            last_frame;
  logic [3:0]      dig4;
  logic [SW-1:0]   shown     [CH];
  logic [6:0]      eff_count [CH];
  logic [7:0]      frame_byte[CH];
  logic [CH-1:0]   ram_we;
  logic [SW-1:0]   ram_waddr [CH];
  logic [SLOTW-1:0] ram_wdata [CH];
  logic            ram_re;
  logic [SLOTW-1:0] ram_rdata [CH];
  sdq_slot_t       rd_slot   [CH];
  sdq_slot_t       wr_slot   [CH];
  logic [SW-1:0]   wr_ptr;
  logic            lock_bad;

  assign busy           = (state_q != S_IDLE);
  assign accept         = start && !busy;
  assign last_frame     = (state_q == S_FRAME) && (dig_q == DW'(DIGITS - 1));
  assign dig4           = 4'(dig_q);
  assign wr_ptr         = wptr_q[req_i.channel];
  assign lock_bad       = ({1'b0, req_i.lock_slot} >= 6'(SLOTS));
  assign ram_re         = accept && (req_i.operation == OP_REFRESH) && enabled_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Per-channel shown slot, frame byte and slot memory access
  for (genvar c = 0; c < CH; c++) begin : g_chan
    assign shown[c]   = pin_q[c] ? pinned_q[c] : show_q[c];
    assign rd_slot[c] = sdq_slot_t'(ram_rdata[c]);
    assign eff_count[c] = valid_q[c][shown[c]] ? rd_slot[c].count : 7'd0;

    always_comb begin
      if (eff_count[c] == 7'd0) begin
        frame_byte[c] = idle_q;
      end else if (dig4 > 4'd3) begin
        frame_byte[c] = 8'd0;
      end else begin
        frame_byte[c] = rd_slot[c].segs[{dig4[1:0], 3'b000} +: 8];
      end
    end

    // Write on a slot write, or write back the decremented count of an unlocked channel on the final frame
    always_comb begin
      wr_slot[c]   = rd_slot[c];
      ram_we[c]    = 1'b0;
      ram_waddr[c] = shown[c];
      if (accept && (req_i.operation == OP_WRITE) && (req_i.channel == 1'(c))
          && (req_i.show_count != 7'd0)) begin
        ram_we[c]        = 1'b1;
        ram_waddr[c]     = wr_ptr;
        wr_slot[c].count = req_i.show_count;
        wr_slot[c].segs  = req_i.segments;
      end else if (last_frame && !pin_q[c] && (eff_count[c] != 7'd0)) begin
        ram_we[c]        = 1'b1;
        wr_slot[c].count = eff_count[c] - 7'd1;
      end
      ram_wdata[c] = SLOTW'(wr_slot[c]);
    end

    sdq_ram #(
      .WIDTH (SLOTW),
      .DEPTH (SLOTS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[c]),
      .waddr_i (ram_waddr[c]),
      .wdata_i (ram_wdata[c]),
      .re_i    (ram_re),
      .raddr_i (shown[c]),
      .rdata_o (ram_rdata[c])
    );
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      idle_q    <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DISPLAY_ENABLED: enabled_q <= cfg_data_i[0];
        REG_IDLE_PATTERN:    idle_q    <= cfg_data_i;
        default:             ;
      endcase
    end
  end

  // Control state, pointers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dig_q       <= '0;
      pin_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      for (int c = 0; c < CH; c++) begin
        show_q[c]   <= '0;
        wptr_q[c]   <= '0;
        pinned_q[c] <= '0;
        valid_q[c]  <= '0;
      end
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_valid_q <= 1'b1;
            res_q       <= '0;
            res_q.last  <= 1'b1;
            case (req_i.operation)
              OP_WRITE: begin
                if (req_i.show_count == 7'd0) begin
                  res_q.status <= STAT_INVALID;
                end else begin
                  res_q.status       <= STAT_OK;
                  res_q.slot_written <= 5'(wr_ptr);
                  valid_q[req_i.channel][wr_ptr] <= 1'b1;
                  wptr_q[req_i.channel] <=
                    (wr_ptr == SW'(SLOTS - 1)) ? '0 : wr_ptr + SW'(1);
                end
              end
              OP_LOCK: begin
                if (lock_bad) begin
                  res_q.status <= STAT_INVALID;
                end else begin
                  res_q.status <= STAT_OK;
                  if (req_i.lock_enable) begin
                    pinned_q[req_i.channel] <= SW'(req_i.lock_slot);
                    pin_q[req_i.channel]    <= 1'b1;
                  end else begin
                    pin_q[req_i.channel] <= 1'b0;
                  end
                end
              end
              OP_REFRESH: begin
                if (!enabled_q) begin
                  res_q.status <= STAT_DISABLED;
                end else begin
                  // hold the result back until the frames start
                  res_valid_q <= 1'b0;
                  dig_q       <= '0;
                  state_q     <= S_FRAME;
                end
              end
              default: res_q.status <= STAT_INVALID;
            endcase
          end
        end
        S_FRAME: begin
          res_valid_q        <= 1'b1;
          res_q.status       <= STAT_OK;
          res_q.slot_written <= 5'd0;
          res_q.seg_first    <= frame_byte[0];
          res_q.seg_second   <= frame_byte[1];
          res_q.digit_select <= 4'b0001 << dig4;
          res_q.last         <= last_frame;
          dig_q              <= dig_q + DW'(1);
          if (last_frame) begin
            state_q <= S_IDLE;
            // advance the show pointer of each unlocked channel that ran out
            for (int c = 0; c < CH; c++) begin
              if (!pin_q[c] && (eff_count[c] == 7'd1)) begin
                show_q[c] <= (show_q[c] == SW'(SLOTS - 1)) ? '0 : show_q[c] + SW'(1);
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/sdq_checker.sv]
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks of the segment display queue, bound to the top level.
// ----------------------------------------------------------------------------
module sdq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input sdq_pkg::sdq_req_t               req_i,
  input logic                            result_valid_o,
  input sdq_pkg::sdq_res_t               result_o
);

  import sdq_pkg::*;

  // A non-refresh request answers in the next cycle with a final result
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation != OP_REFRESH)) |=>
      (result_valid_o && result_o.last))
    else $error("non-refresh request gave no final result in next cycle");

  // A result only follows a request or a refresh in progress
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start || busy))
    else $error("result without a request");

  // Frames carry one digit and a clean status
  a_frame_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.digit_select != 4'd0)) |->
      ($onehot(result_o.digit_select) && (result_o.status == STAT_OK)
       && (result_o.slot_written == 5'd0)))
    else $error("malformed refresh frame");

  // Errors are always single final results
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status != STAT_OK)) |->
      (result_o.last && (result_o.digit_select == 4'd0)))
    else $error("error result not final");

endmodule

bind segment_display_queue_unit sdq_checker u_sdq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
